### rtl/rlebgr_pkg.sv
`timescale 1ns / 1ps

package rlebgr_pkg;

   // byte phase within a control word or a color word
   localparam logic [1:0] PH_CTL_LO = 2'd0;
   localparam logic [1:0] PH_CTL_HI = 2'd1;
   localparam logic [1:0] PH_COL_LO = 2'd2;
   localparam logic [1:0] PH_COL_HI = 2'd3;

   // frame status codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TRUNC    = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW = 3'd2;
   localparam logic [2:0] ERR_SHORT    = 3'd3;
   localparam logic [2:0] ERR_TRAIL    = 3'd4;

   typedef struct packed {
      logic [1:0]  phase;
      logic [7:0]  low_latch;
      logic        fill_mode;
      logic [15:0] literal_left;
      logic [2:0]  first_error;
   } state_type;

   typedef struct packed {
      logic        pixel_write;
      logic [15:0] pixel_index;
      logic [15:0] run_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        frame_end;
      logic        frame_ok;
      logic [2:0]  error_code;
   } result_type;

   // 5-bit to 8-bit component expansion by bit replication
   function automatic logic [7:0] expand5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

endpackage

### rtl/rle_bgr555_frame_decoder_core.sv
`timescale 1ns / 1ps

// channel | direction | tdata (low bit up)                       | tuser        | tlast
// req     | in        | data_byte[7:0]                           | -            | last_byte
// rsp     | out       | pixel_index[15:0] run_count[31:16]       | pixel_write  | frame_end
//         |           | red[39:32] green[47:40] blue[55:48]      |              |
//         |           | frame_ok[56] error_code[59:57] zero[63:60]|             |
//
// One byte transaction in, one result transaction out: the decode
// step is a single combinational pass from the frame state registers into the
// result register, so a new byte is taken every cycle while rsp is drained.
// rsp turns valid in the cycle after req accepts the byte.
// Reset (synchronous, active high) clears the frame state and empties rsp.
// A stalled rsp holds its result and drops req_tready until it is taken.

module rle_bgr555_frame_decoder_core #(
   parameter int SCREEN_PIXELS = 57344
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pixel_index, run_count, red, green, blue,
                                    // frame_ok, error_code, zero fill
   output logic        rsp_tuser,   // pixel_write
   output logic        rsp_tlast
);

   localparam int PD_W  = $clog2(SCREEN_PIXELS + 1);
   localparam int CNT_W = (PD_W > 17) ? PD_W : 17;

   rlebgr_pkg::state_type  state_ff;
   rlebgr_pkg::state_type  state_in;
   logic [CNT_W-1:0]       pixels_ff;   // pixels written so far in this frame
   logic [CNT_W-1:0]       pixels_in;
   rlebgr_pkg::result_type step_result;
   rlebgr_pkg::result_type rsp_result;
   logic                   space;
   logic                   accept;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   rlebgr_step #(
      .SCREEN_PIXELS(SCREEN_PIXELS)
   ) u_step (
      .state_cur (state_ff),
      .pixels_cur(pixels_ff),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .state_nxt (state_in),
      .pixels_nxt(pixels_in),
      .result    (step_result)
   );

   // frame state advances only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         pixels_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         pixels_ff <= pixels_in;
      end
   end

   rlebgr_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .load_data(step_result),
      .space    (space),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_data (rsp_result)
   );

   assign rsp_tdata = {4'b0000,
                       rsp_result.error_code,
                       rsp_result.frame_ok,
                       rsp_result.blue,
                       rsp_result.green,
                       rsp_result.red,
                       rsp_result.run_count,
                       rsp_result.pixel_index};
   assign rsp_tuser = rsp_result.pixel_write;
   assign rsp_tlast = rsp_result.frame_end;

endmodule

### rtl/rlebgr_step.sv
`timescale 1ns / 1ps

module rlebgr_step #(
   parameter int SCREEN_PIXELS = 57344,
   localparam int PD_W  = $clog2(SCREEN_PIXELS + 1),
   localparam int CNT_W = (PD_W > 17) ? PD_W : 17
) (
   input  rlebgr_pkg::state_type  state_cur,
   input  logic [CNT_W-1:0]       pixels_cur,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output rlebgr_pkg::state_type  state_nxt,
   output logic [CNT_W-1:0]       pixels_nxt,
   output rlebgr_pkg::result_type result
);

   localparam logic [CNT_W-1:0] SCREEN = CNT_W'(SCREEN_PIXELS);

   logic [15:0]      run_len;
   logic [CNT_W-1:0] room;
   logic [15:0]      lit_dec;
   logic [15:0]      color;

   assign run_len = {1'b0, data_byte[6:0], state_cur.low_latch} + 16'd1;
   assign room    = SCREEN - pixels_cur;
   assign lit_dec = state_cur.literal_left - 16'd1;
   assign color   = {data_byte, state_cur.low_latch};

   always_comb begin
      state_nxt  = state_cur;
      pixels_nxt = pixels_cur;
      result     = '0;

      if (state_cur.first_error == rlebgr_pkg::ERR_NONE) begin
         case (state_cur.phase)
            rlebgr_pkg::PH_CTL_LO: begin
               if (pixels_cur >= SCREEN) begin
                  state_nxt.first_error = rlebgr_pkg::ERR_TRAIL;
               end else begin
                  state_nxt.low_latch = data_byte;
                  state_nxt.phase     = rlebgr_pkg::PH_CTL_HI;
               end
            end
            rlebgr_pkg::PH_CTL_HI: begin
               if (CNT_W'(run_len) > room) begin
                  state_nxt.first_error = rlebgr_pkg::ERR_OVERFLOW;
               end else begin
                  state_nxt.fill_mode    = data_byte[7];
                  state_nxt.literal_left = run_len;
                  state_nxt.phase        = rlebgr_pkg::PH_COL_LO;
               end
            end
            rlebgr_pkg::PH_COL_LO: begin
               state_nxt.low_latch = data_byte;
               state_nxt.phase     = rlebgr_pkg::PH_COL_HI;
            end
            rlebgr_pkg::PH_COL_HI: begin
               result.pixel_write = 1'b1;
               result.pixel_index = pixels_cur[15:0];
               result.red         = rlebgr_pkg::expand5(color[4:0]);
               result.green       = rlebgr_pkg::expand5(color[9:5]);
               result.blue        = rlebgr_pkg::expand5(color[14:10]);
               if (state_cur.fill_mode) begin
                  result.run_count       = state_cur.literal_left;
                  pixels_nxt             = pixels_cur + CNT_W'(state_cur.literal_left);
                  state_nxt.literal_left = '0;
                  state_nxt.phase        = rlebgr_pkg::PH_CTL_LO;
               end else begin
                  result.run_count       = 16'd1;
                  pixels_nxt             = pixels_cur + CNT_W'(1);
                  state_nxt.literal_left = lit_dec;
                  state_nxt.phase        = (lit_dec != 16'd0) ? rlebgr_pkg::PH_COL_LO
                                                              : rlebgr_pkg::PH_CTL_LO;
               end
            end
            default: begin
               state_nxt = state_cur;
            end
         endcase
      end

      // last byte: settle frame status, then back to the idle frame state
      if (last_byte) begin
         if (state_nxt.first_error == rlebgr_pkg::ERR_NONE) begin
            if (state_nxt.phase != rlebgr_pkg::PH_CTL_LO) begin
               state_nxt.first_error = rlebgr_pkg::ERR_TRUNC;
            end else if (pixels_nxt != SCREEN) begin
               state_nxt.first_error = rlebgr_pkg::ERR_SHORT;
            end
         end
         result.frame_end  = 1'b1;
         result.error_code = state_nxt.first_error;
         result.frame_ok   = (state_nxt.first_error == rlebgr_pkg::ERR_NONE);
         state_nxt         = '0;
         pixels_nxt        = '0;
      end
   end

endmodule

### rtl/rlebgr_rsp_reg.sv
`timescale 1ns / 1ps

module rlebgr_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rlebgr_pkg::result_type load_data,
   output logic                   space,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlebgr_pkg::result_type rsp_data
);

   logic                   valid_ff;
   logic                   valid_in;
   rlebgr_pkg::result_type data_ff;

   // full register may be refilled in the cycle it drains
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/rlebgr_checker.sv
`timescale 1ns / 1ps

module rlebgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // an empty result register always takes a byte
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty rsp");

   // an accepted byte always yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   // status fields are zero off frame end; at frame end ok matches a zero code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast ? (rsp_tdata[56] == (rsp_tdata[59:57] == 3'd0))
                                : (rsp_tdata[59:56] == 4'd0)))
      else $error("frame status inconsistent");

   // no pixel write means zero pixel fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[55:0] == 56'd0)
      else $error("idle pixel fields not zero");

endmodule

bind rle_bgr555_frame_decoder_core rlebgr_checker u_checker (.*);

### bench/rle_bgr555_frame_decoder_core_test.sv
`timescale 1ns / 1ps

module rle_bgr555_frame_decoder_core_test;

   localparam int          SCREEN_PIXELS = 57344;
   localparam logic [16:0] SCREEN        = 17'(SCREEN_PIXELS);

   // how a random frame is ended or broken
   localparam int FRAME_CLEAN    = 0;
   localparam int FRAME_TRAILING = 1;
   localparam int FRAME_TRUNCATE = 2;
   localparam int FRAME_SHORT    = 3;
   localparam int FRAME_OVERFLOW = 4;
   localparam int FRAME_NOISE    = 5;

   localparam int RANDOM_BYTES = 1050;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;   // pixel_index, run_count, red, green, blue, frame_ok, error_code
   logic        rsp_tuser;   // pixel_write
   logic        rsp_tlast;

   rle_bgr555_frame_decoder_core #(
      .SCREEN_PIXELS(SCREEN_PIXELS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // frame decode prediction
   // ---------------------------------------------------------------------------------
   logic [1:0]  dec_phase   = rlebgr_pkg::PH_CTL_LO;
   logic [7:0]  dec_low     = 8'h00;
   logic        dec_fill    = 1'b0;
   logic [15:0] dec_left    = 16'h0000;
   logic [16:0] dec_done    = 17'h00000;
   logic [2:0]  dec_err     = rlebgr_pkg::ERR_NONE;

   rlebgr_pkg::result_type decoded_q[$];
   int          mismatches = 0;
   int          cycle_count = 0;

   function automatic logic [7:0] widen5(input logic [4:0] c);
      widen5 = {c, 3'b000} | {5'b00000, c[4:2]};
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last);
      rlebgr_pkg::result_type r;
      logic [15:0] word;
      logic [16:0] run;
      logic [16:0] room;
      r = '0;
      if (dec_err == rlebgr_pkg::ERR_NONE) begin
         word = {b, dec_low};
         case (dec_phase)
            rlebgr_pkg::PH_CTL_LO: begin
               if (dec_done >= SCREEN) begin
                  dec_err = rlebgr_pkg::ERR_TRAIL;
               end else begin
                  dec_low   = b;
                  dec_phase = rlebgr_pkg::PH_CTL_HI;
               end
            end
            rlebgr_pkg::PH_CTL_HI: begin
               run  = {2'b00, word[14:0]} + 17'd1;
               room = SCREEN - dec_done;
               if (run > room) begin
                  dec_err = rlebgr_pkg::ERR_OVERFLOW;
               end else begin
                  dec_fill  = word[15];
                  dec_left  = run[15:0];
                  dec_phase = rlebgr_pkg::PH_COL_LO;
               end
            end
            rlebgr_pkg::PH_COL_LO: begin
               dec_low   = b;
               dec_phase = rlebgr_pkg::PH_COL_HI;
            end
            default: begin
               r.pixel_write = 1'b1;
               r.pixel_index = dec_done[15:0];
               r.red         = widen5(word[4:0]);
               r.green       = widen5(word[9:5]);
               r.blue        = widen5(word[14:10]);
               if (dec_fill) begin
                  r.run_count = dec_left;
                  dec_done    = dec_done + {1'b0, dec_left};
                  dec_left    = 16'h0000;
                  dec_phase   = rlebgr_pkg::PH_CTL_LO;
               end else begin
                  r.run_count = 16'd1;
                  dec_done    = dec_done + 17'd1;
                  dec_left    = dec_left - 16'd1;
                  dec_phase   = (dec_left != 16'h0000) ? rlebgr_pkg::PH_COL_LO
                                                       : rlebgr_pkg::PH_CTL_LO;
               end
            end
         endcase
      end
      if (last) begin
         if (dec_err == rlebgr_pkg::ERR_NONE) begin
            if (dec_phase != rlebgr_pkg::PH_CTL_LO)
               dec_err = rlebgr_pkg::ERR_TRUNC;
            else if (dec_done != SCREEN)
               dec_err = rlebgr_pkg::ERR_SHORT;
         end
         r.frame_end  = 1'b1;
         r.error_code = dec_err;
         r.frame_ok   = (dec_err == rlebgr_pkg::ERR_NONE);
         // back to a fresh frame
         dec_phase = rlebgr_pkg::PH_CTL_LO;
         dec_low   = 8'h00;
         dec_fill  = 1'b0;
         dec_left  = 16'h0000;
         dec_done  = 17'h00000;
         dec_err   = rlebgr_pkg::ERR_NONE;
      end
      decoded_q.push_back(r);
   endtask

   // ---------------------------------------------------------------------------------
   // frame building
   // ---------------------------------------------------------------------------------
   byte_item_type pending_bytes[$];
   logic [7:0] frame_buf[$];
   int         ctl_starts[$];
   int         random_count = 0;

   task automatic push_byte(input logic [7:0] b);
      frame_buf.push_back(b);
   endtask

   task automatic push_word(input logic [15:0] w, input bit is_ctl);
      if (is_ctl)
         ctl_starts.push_back(frame_buf.size());
      frame_buf.push_back(w[7:0]);
      frame_buf.push_back(w[15:8]);
   endtask

   // move the built frame onto the stream, tlast on its final byte
   task automatic finish_frame();
      byte_item_type it;
      for (int i = 0; i < frame_buf.size(); i++) begin
         it.data = frame_buf[i];
         it.last = (i == frame_buf.size() - 1);
         pending_bytes.push_back(it);
      end
      random_count += frame_buf.size();
      frame_buf.delete();
      ctl_starts.delete();
   endtask

   task automatic gen_frame();
      int pick;
      int mode;
      int remaining;
      int run;
      int lim;
      int n;
      int cut;
      pick = $urandom_range(0, 99);
      if (pick < 45)      mode = FRAME_CLEAN;
      else if (pick < 57) mode = FRAME_TRAILING;
      else if (pick < 69) mode = FRAME_TRUNCATE;
      else if (pick < 79) mode = FRAME_SHORT;
      else if (pick < 92) mode = FRAME_OVERFLOW;
      else                mode = FRAME_NOISE;

      if (mode == FRAME_NOISE) begin
         n = $urandom_range(1, 12);
         repeat (n) push_byte(8'($urandom));
      end else begin
         remaining = SCREEN_PIXELS;
         while (remaining > 0) begin
            // a run longer than the room left, then some junk
            if (mode == FRAME_OVERFLOW && remaining < 32768 && $urandom_range(0, 2) != 0) begin
               run = $urandom_range(remaining + 1, 32768);
               push_word({1'($urandom), 15'(run - 1)}, 1'b1);
               n = $urandom_range(0, 3);
               repeat (n) push_byte(8'($urandom));
               break;
            end
            if ($urandom_range(0, 3) == 0) begin
               lim = (remaining < 4) ? remaining : 4;
               n   = $urandom_range(1, lim);
               push_word({1'b0, 15'(n - 1)}, 1'b1);
               repeat (n) push_word(16'($urandom), 1'b0);
               remaining -= n;
            end else begin
               lim = (remaining < 32768) ? remaining : 32768;
               run = ($urandom_range(0, 1) != 0) ? lim : $urandom_range(1, lim);
               push_word({1'b1, 15'(run - 1)}, 1'b1);
               push_word(16'($urandom), 1'b0);
               remaining -= run;
            end
         end
         case (mode)
            FRAME_TRAILING: begin
               n = $urandom_range(1, 3);
               repeat (n) push_byte(8'($urandom));
            end
            FRAME_TRUNCATE: begin
               cut = $urandom_range(1, frame_buf.size() - 1);
               while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end
            FRAME_SHORT: begin
               cut = ctl_starts[$urandom_range(1, ctl_starts.size() - 1)];
               while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end
            default: ;
         endcase
      end
      finish_frame();
   endtask

   // ---------------------------------------------------------------------------------
   // idling: ~23% on each side, none in a window partway through
   // ---------------------------------------------------------------------------------
   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic bit take_break();
      if (cycle_count >= 800 && cycle_count < 1300)
         return 1'b0;
      return ($urandom_range(0, 99) < 23);
   endfunction

   // ---------------------------------------------------------------------------------
   // driver: hold tvalid until taken, predict on every accepted byte
   // ---------------------------------------------------------------------------------
   byte_item_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && !take_break()) begin
               next_byte   = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // monitor
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   rlebgr_pkg::result_type want_res;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("result transaction with no byte outstanding");
            end else begin
               want_res = decoded_q.pop_front();
               check_field("pixel_write", rsp_tuser,         want_res.pixel_write);
               check_field("pixel_index", rsp_tdata[15:0],   want_res.pixel_index);
               check_field("run_count",   rsp_tdata[31:16],  want_res.run_count);
               check_field("red",         rsp_tdata[39:32],  want_res.red);
               check_field("green",       rsp_tdata[47:40],  want_res.green);
               check_field("blue",        rsp_tdata[55:48],  want_res.blue);
               check_field("frame_end",   rsp_tlast,         want_res.frame_end);
               check_field("frame_ok",    rsp_tdata[56],     want_res.frame_ok);
               check_field("error_code",  rsp_tdata[59:57],  want_res.error_code);
            end
         end
         rsp_tready <= !take_break();
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------
   initial begin
      // clean: max fill from index 0, then the rest, all-ones color (bit 15 ignored)
      push_word(16'hFFFF, 1'b1);
      push_word(16'h0000, 1'b0);
      push_word(16'hDFFF, 1'b1);
      push_word(16'hFFFF, 1'b0);
      finish_frame();
      // one literal, then a short frame
      push_word(16'h0000, 1'b1);
      push_word(16'h7C1F, 1'b0);
      finish_frame();
      // truncated inside a control word
      push_byte(8'hA5);
      finish_frame();
      // run overflow on the second control word's high byte
      push_word(16'hFFFF, 1'b1);
      push_word(16'h1234, 1'b0);
      push_word(16'h6000, 1'b1);
      finish_frame();
      // full frame, then trailing data
      push_word(16'hFFFF, 1'b1);
      push_word(16'h03E0, 1'b0);
      push_word(16'hDFFF, 1'b1);
      push_word(16'h7C00, 1'b0);
      push_byte(8'h55);
      finish_frame();

      random_count = 0;
      while (random_count < RANDOM_BYTES)
         gen_frame();

      while (reset) @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
